/* rtl/dtd_pkg.sv */
// Shared types, constants and calendar helpers for the date-time difference block.
// Used by dtd_ctrl, dtd_datapath and the top level; depends on nothing.
package dtd_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned DurW    = 40;

  localparam int unsigned MulAW   = 25;
  localparam int unsigned MulBW   = 18;

  localparam int unsigned Recip100   = 5243;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned QuotW      = 8;

  localparam int unsigned SecPerDay  = 86400;
  localparam int unsigned SecPerHour = 3600;
  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned DaysPerYear = 365;

  localparam logic [MonthW-1:0] LastMonth = 4'd12;

  typedef struct packed {
    logic [YearW-1:0]  from_year;
    logic [MonthW-1:0] from_month;
    logic [DayW-1:0]   from_day;
    logic [HourW-1:0]  from_hour;
    logic [MinW-1:0]   from_minute;
    logic [SecW-1:0]   from_second;
    logic [YearW-1:0]  to_year;
    logic [MonthW-1:0] to_month;
    logic [DayW-1:0]   to_day;
    logic [HourW-1:0]  to_hour;
    logic [MinW-1:0]   to_minute;
    logic [SecW-1:0]   to_second;
  } dtd_item_t;

  typedef enum logic [2:0] {
    MUL_HOLD,
    MUL_Q_YEAR,
    MUL_Q_PREV,
    MUL_YEARS,
    MUL_DAY,
    MUL_HOUR,
    MUL_MIN
  } mul_sel_t;

  typedef enum logic [2:0] {
    ADD_MONTH,
    ADD_LEAP_PREV,
    ADD_LEAP_START,
    ADD_PROD,
    ADD_DAY_DIFF,
    ADD_SEC_DIFF
  } add_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD,
    ACC_LOAD
  } acc_op_t;

  typedef struct packed {
    mul_sel_t mul;
    add_sel_t add;
    acc_op_t  acc;
    logic     use_end;
    logic     month_init;
    logic     month_step;
    logic     leap_latch;
  } dtd_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic in_order;
    logic later_year;
    logic gap_years;
  } dtd_status_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] d;
    d = '0;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = '0;
    endcase
    return d;
  endfunction

endpackage

/* rtl/dtd_ctrl.sv */
// Sequencer for the date-time difference block: steps the shared datapath
// through the month walk, leap-year count and seconds scaling. Uses dtd_pkg.
module dtd_ctrl import dtd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic        out_free,
  input  dtd_status_t status,
  output dtd_cmd_t    cmd,
  output logic        busy,
  output logic        finish
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_LEAP_S,
    S_WALK_S,
    S_Q_END,
    S_LEAP_E,
    S_WALK_E,
    S_Q_PREV,
    S_LEAP_P,
    S_LEAP_SY,
    S_ADD_Y,
    S_DAYS,
    S_MUL_DAY,
    S_LOAD_DAY,
    S_ADD_HR,
    S_ADD_MIN,
    S_ADD_SEC,
    S_DONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.mul        = MUL_HOLD;
    cmd.add        = ADD_MONTH;
    cmd.acc        = ACC_HOLD;
    finish         = 1'b0;
    case (state)
      S_IDLE: begin
        if (go) state_next = S_INIT;
      end
      S_INIT: begin
        cmd.acc        = ACC_CLEAR;
        cmd.mul        = MUL_Q_YEAR;
        cmd.month_init = 1'b1;
        state_next     = S_LEAP_S;
      end
      S_LEAP_S: begin
        cmd.leap_latch = 1'b1;
        state_next     = status.in_order ? S_WALK_S : S_DAYS;
      end
      S_WALK_S: begin
        if (status.walk_done) begin
          state_next = status.later_year ? S_Q_END : S_DAYS;
        end else begin
          cmd.acc        = ACC_ADD;
          cmd.add        = ADD_MONTH;
          cmd.month_step = 1'b1;
        end
      end
      S_Q_END: begin
        cmd.use_end    = 1'b1;
        cmd.mul        = MUL_Q_YEAR;
        cmd.month_init = 1'b1;
        state_next     = S_LEAP_E;
      end
      S_LEAP_E: begin
        cmd.use_end    = 1'b1;
        cmd.leap_latch = 1'b1;
        state_next     = S_WALK_E;
      end
      S_WALK_E: begin
        cmd.use_end = 1'b1;
        if (status.walk_done) begin
          state_next = status.gap_years ? S_Q_PREV : S_DAYS;
        end else begin
          cmd.acc        = ACC_ADD;
          cmd.add        = ADD_MONTH;
          cmd.month_step = 1'b1;
        end
      end
      S_Q_PREV: begin
        cmd.mul    = MUL_Q_PREV;
        state_next = S_LEAP_P;
      end
      S_LEAP_P: begin
        cmd.acc    = ACC_ADD;
        cmd.add    = ADD_LEAP_PREV;
        cmd.mul    = MUL_Q_YEAR;
        state_next = S_LEAP_SY;
      end
      S_LEAP_SY: begin
        cmd.acc    = ACC_ADD;
        cmd.add    = ADD_LEAP_START;
        cmd.mul    = MUL_YEARS;
        state_next = S_ADD_Y;
      end
      S_ADD_Y: begin
        cmd.acc    = ACC_ADD;
        cmd.add    = ADD_PROD;
        state_next = S_DAYS;
      end
      S_DAYS: begin
        cmd.acc    = ACC_ADD;
        cmd.add    = ADD_DAY_DIFF;
        state_next = S_MUL_DAY;
      end
      S_MUL_DAY: begin
        cmd.mul    = MUL_DAY;
        state_next = S_LOAD_DAY;
      end
      S_LOAD_DAY: begin
        cmd.acc    = ACC_LOAD;
        cmd.mul    = MUL_HOUR;
        state_next = S_ADD_HR;
      end
      S_ADD_HR: begin
        cmd.acc    = ACC_ADD;
        cmd.add    = ADD_PROD;
        cmd.mul    = MUL_MIN;
        state_next = S_ADD_MIN;
      end
      S_ADD_MIN: begin
        cmd.acc    = ACC_ADD;
        cmd.add    = ADD_PROD;
        state_next = S_ADD_SEC;
      end
      S_ADD_SEC: begin
        cmd.acc    = ACC_ADD;
        cmd.add    = ADD_SEC_DIFF;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/dtd_datapath.sv */
// Shared arithmetic for the date-time difference block: one multiplier with a
// product register, one accumulator adder, month counter and leap flag. Uses dtd_pkg.
module dtd_datapath import dtd_pkg::*; (
  input  logic                   clk,
  input  dtd_item_t              item,
  input  dtd_cmd_t               cmd,
  output dtd_status_t            status,
  output logic signed [DurW-1:0] acc
);

  logic        [MonthW-1:0]    month;
  logic                        leap;
  logic signed [DurW-1:0]      prod;

  logic        [YearW-1:0]     year_sel;
  logic        [YearW-1:0]     prev_year;
  logic        [QuotW-1:0]     quot;
  logic        [YearW-1:0]     quot_x100;
  logic        [YearW-1:0]     leap_base;
  logic        [YearW-1:0]     leap_count;
  logic                        has_stop;
  logic signed [MulAW-1:0]     mul_a;
  logic signed [MulBW-1:0]     mul_b;
  logic signed [MulAW+MulBW-1:0] mul_p;
  logic signed [DayW:0]        day_diff;
  logic signed [HourW:0]       hour_diff;
  logic signed [MinW:0]        min_diff;
  logic signed [SecW:0]        sec_diff;
  logic signed [DurW-1:0]      addend;

  assign year_sel  = cmd.use_end ? item.to_year : item.from_year;
  assign prev_year = item.to_year - YearW'(1);
  assign quot      = prod[RecipShift +: QuotW];
  assign quot_x100 = YearW'(quot) * YearW'(100);

  assign leap_base  = (cmd.add == ADD_LEAP_PREV) ? prev_year : item.from_year;
  assign leap_count = (leap_base >> 2) - YearW'(quot) + YearW'(quot >> 2);

  assign day_diff  = $signed({1'b0, item.to_day})    - $signed({1'b0, item.from_day});
  assign hour_diff = $signed({1'b0, item.to_hour})   - $signed({1'b0, item.from_hour});
  assign min_diff  = $signed({1'b0, item.to_minute}) - $signed({1'b0, item.from_minute});
  assign sec_diff  = $signed({1'b0, item.to_second}) - $signed({1'b0, item.from_second});

  assign has_stop = cmd.use_end || (item.from_year == item.to_year);

  assign status.walk_done  = (month > LastMonth) || (has_stop && (month == item.to_month));
  assign status.in_order   = (item.from_year <= item.to_year);
  assign status.later_year = (item.to_year > item.from_year);
  assign status.gap_years  = ((YearW + 1)'(item.from_year) + (YearW + 1)'(1))
                             < (YearW + 1)'(item.to_year);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      MUL_Q_YEAR: begin
        mul_a = $signed(MulAW'(year_sel));
        mul_b = MulBW'(Recip100);
      end
      MUL_Q_PREV: begin
        mul_a = $signed(MulAW'(prev_year));
        mul_b = MulBW'(Recip100);
      end
      MUL_YEARS: begin
        mul_a = $signed(MulAW'(item.to_year - item.from_year - YearW'(1)));
        mul_b = MulBW'(DaysPerYear);
      end
      MUL_DAY: begin
        mul_a = acc[MulAW-1:0];
        mul_b = MulBW'(SecPerDay);
      end
      MUL_HOUR: begin
        mul_a = MulAW'(hour_diff);
        mul_b = MulBW'(SecPerHour);
      end
      MUL_MIN: begin
        mul_a = MulAW'(min_diff);
        mul_b = MulBW'(SecPerMin);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (cmd.add)
      ADD_MONTH:      addend = $signed(DurW'(month_days(month, leap)));
      ADD_LEAP_PREV:  addend = $signed(DurW'(leap_count));
      ADD_LEAP_START: addend = -$signed(DurW'(leap_count));
      ADD_PROD:       addend = prod;
      ADD_DAY_DIFF:   addend = DurW'(day_diff);
      ADD_SEC_DIFF:   addend = DurW'(sec_diff);
      default:        addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul != MUL_HOLD) begin
      prod <= DurW'(mul_p);
    end
    case (cmd.acc)
      ACC_CLEAR: acc <= '0;
      ACC_ADD:   acc <= acc + addend;
      ACC_LOAD:  acc <= prod;
      default:   acc <= acc;
    endcase
    if (cmd.month_init) begin
      month <= cmd.use_end ? MonthW'(1) : item.from_month;
    end else if (cmd.month_step) begin
      month <= month + MonthW'(1);
    end
    if (cmd.leap_latch) begin
      leap <= (year_sel[1:0] == 2'b00) &&
              ((quot_x100 != year_sel) || (quot[1:0] == 2'b00));
    end
  end

endmodule

/* rtl/datetime_difference_seconds_top.sv */
// Top level of the date-time difference block: input and output registers,
// handshakes, and the sequencer and datapath instances. Uses dtd_pkg.
//
// Usage: present a start and an end date-time on the input channel with
// in_valid; the item transfers at a rising edge with in_valid high and
// in_stall low. The block then raises in_stall while it works on the item.
// The signed duration in seconds appears on duration_seconds with out_valid
// and transfers at an edge with out_valid high and out_stall low.
// Output comes soonest when the end year is before the start year, latest
// when both first and last year are walked in full. The month walk adds
// one month per cycle through the shared accumulator; whole years between
// are counted with the shared multiplier via the previous-year quotient,
// leap counts and year product. One item is in flight at a time; the next
// input transfer can happen the cycle after the result is loaded.
// A finished result waits in the output register while the receiver stalls;
// the block holds its last step until that register is free.
// Reset clears the sequencer and out_valid; in_stall is low after reset.
module datetime_difference_seconds_top import dtd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [YearW-1:0]       from_year,
  input  logic [MonthW-1:0]      from_month,
  input  logic [DayW-1:0]        from_day,
  input  logic [HourW-1:0]       from_hour,
  input  logic [MinW-1:0]        from_minute,
  input  logic [SecW-1:0]        from_second,
  input  logic [YearW-1:0]       to_year,
  input  logic [MonthW-1:0]      to_month,
  input  logic [DayW-1:0]        to_day,
  input  logic [HourW-1:0]       to_hour,
  input  logic [MinW-1:0]        to_minute,
  input  logic [SecW-1:0]        to_second,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [DurW-1:0] duration_seconds
);

  dtd_item_t              item;
  dtd_cmd_t               cmd;
  dtd_status_t            status;
  logic signed [DurW-1:0] acc;
  logic                   busy;
  logic                   finish;
  logic                   in_xfer;
  logic                   out_free;

  assign in_stall = busy;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item <= '{from_year, from_month, from_day, from_hour, from_minute,
                from_second, to_year, to_month, to_day, to_hour,
                to_minute, to_second};
    end
    if (finish) begin
      duration_seconds <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  dtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .go       (in_xfer),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .finish   (finish)
  );

  dtd_datapath u_datapath (
    .clk    (clk),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .acc    (acc)
  );

endmodule

/* rtl/dtd_checker.sv */
// Port-level checks for the date-time difference block, bound to the top level.
// Sees only the top-level ports; uses dtd_pkg for widths.
module dtd_checker import dtd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic signed [DurW-1:0] duration_seconds
);

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second transfer while working");

  a_result_ends_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("new result while sequencer still busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(duration_seconds))
    else $error("stalled result dropped or changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("control not cleared by reset");

endmodule

bind datetime_difference_seconds_top dtd_checker u_dtd_checker (.*);
